### src/iarr_pkg.sv
// iarr_pkg: codes, widths and types shared by the indexed array unit
// no dependencies; compiled first
`default_nettype none

package iarr_pkg;

   // payload widths fixed by the request and response formats
   localparam int OP_W      = 3;
   localparam int POS_W     = 5;
   localparam int DATA_W    = 32;
   localparam int ST_W      = 2;
   localparam int FPOS_W    = 4;
   localparam int CNT_OUT_W = 5;

   // operation codes
   localparam logic [OP_W-1:0] OP_READ   = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
   localparam logic [OP_W-1:0] OP_APPEND = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd5;
   localparam logic [OP_W-1:0] OP_SHL    = 3'd6;
   localparam logic [OP_W-1:0] OP_SHR    = 3'd7;

   // status codes
   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
   localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_ROTATE,
      S_SHIFT,
      S_FINISH
   } state_type;

   // move broadcast to every cell of the row
   typedef enum logic [2:0] {
      MV_HOLD,
      MV_WRITE,
      MV_INSERT,
      MV_REMOVE,
      MV_SHL,
      MV_SHR,
      MV_ROTATE
   } move_type;

endpackage

`default_nettype wire

### src/iarr_req_if.sv
// iarr_req_if: request channel, valid/ready with operation payload
// depends on iarr_pkg
`default_nettype none

interface iarr_req_if;
   logic                               valid;
   logic                               ready;
   logic [iarr_pkg::OP_W-1:0]          operation;
   logic [iarr_pkg::POS_W-1:0]         position;
   logic signed [iarr_pkg::DATA_W-1:0] data_value;
   logic [iarr_pkg::POS_W-1:0]         shift_amount;

   modport source (output valid, operation, position, data_value, shift_amount,
                   input ready);
   modport sink   (input valid, operation, position, data_value, shift_amount,
                   output ready);
endinterface

`default_nettype wire

### src/iarr_rsp_if.sv
// iarr_rsp_if: response channel, valid/ready with result payload
// depends on iarr_pkg
`default_nettype none

interface iarr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [iarr_pkg::DATA_W-1:0]  read_value;
   logic [iarr_pkg::FPOS_W-1:0]         found_position;
   logic [iarr_pkg::ST_W-1:0]           status;
   logic [iarr_pkg::CNT_OUT_W-1:0]      element_count;
   logic                                is_empty;

   modport source (output valid, read_value, found_position, status, element_count,
                   is_empty, input ready);
   modport sink   (input valid, read_value, found_position, status, element_count,
                   is_empty, output ready);
endinterface

`default_nettype wire

### src/iarr_cell.sv
// iarr_cell: one element of the row; picks its next word from itself,
// its neighbours or the broadcast data. depends on iarr_pkg
`default_nettype none

module iarr_cell #(
   parameter int CW    = 5,
   parameter int INDEX = 0
) (
   input  wire logic                               clock,
   input  wire iarr_pkg::move_type                 move,
   input  wire logic [CW-1:0]                      pos,
   input  wire logic [CW-1:0]                      count,
   input  wire logic signed [iarr_pkg::DATA_W-1:0] data,
   input  wire logic signed [iarr_pkg::DATA_W-1:0] lower,
   input  wire logic signed [iarr_pkg::DATA_W-1:0] upper,
   output logic signed [iarr_pkg::DATA_W-1:0]      value
);

   logic signed [iarr_pkg::DATA_W-1:0] value_ff, value_in;
   logic [CW:0] idx_w, idx_p1, pos_w, cnt_w;

   // own index and operands, one bit wider so index + 1 never wraps
   assign idx_w  = (CW+1)'(INDEX);
   assign idx_p1 = idx_w + (CW+1)'(1);
   assign pos_w  = {1'b0, pos};
   assign cnt_w  = {1'b0, count};

   // next word for this place
   always_comb begin
      value_in = value_ff;
      case (move)
         iarr_pkg::MV_WRITE: begin
            if (idx_w == pos_w) value_in = data;
         end
         iarr_pkg::MV_INSERT: begin
            if (idx_w == pos_w) value_in = data;
            else if (idx_w > pos_w && idx_w <= cnt_w) value_in = lower;
         end
         iarr_pkg::MV_REMOVE: begin
            if (idx_w >= pos_w && idx_p1 < cnt_w) value_in = upper;
         end
         iarr_pkg::MV_SHL: begin
            if (idx_p1 < cnt_w) value_in = upper;
            else if (idx_p1 == cnt_w) value_in = '0;
         end
         iarr_pkg::MV_SHR: begin
            if (idx_w < cnt_w) value_in = (idx_w == '0) ? '0 : lower;
         end
         iarr_pkg::MV_ROTATE: begin
            value_in = upper;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // element register
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

### src/indexed_array_with_insert_remove_unit.sv
// indexed array with insert/remove: a row of CAPACITY cells under one sequencer
// result passes the execute and finish states into the output register; read and find
// also pass the rotate state (the row rotates once past cell 0); shifts pass the shift state,
// min(shift_amount, count) places, one place per cycle; finish waits while the output register
// still holds an unaccepted result; one request at a time, taken in the cycle after the last
// result is loaded; synchronous reset empties the array and output register, not the cells
`default_nettype none

module indexed_array_with_insert_remove_unit #(
   parameter int CAPACITY = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   iarr_req_if.sink   req_if,
   iarr_rsp_if.source rsp_if
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = $clog2(CAPACITY);
   localparam int MW = (CW > iarr_pkg::POS_W) ? CW : iarr_pkg::POS_W;

   // sequencer and request registers
   iarr_pkg::state_type state_ff, state_in;
   logic [iarr_pkg::OP_W-1:0]          op_ff, op_in;
   logic [iarr_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic signed [iarr_pkg::DATA_W-1:0] data_ff, data_in;
   logic [iarr_pkg::POS_W-1:0]         amt_ff, amt_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [SW-1:0]                      step_ff, step_in;
   logic [CW-1:0]                      iter_ff, iter_in;
   logic signed [iarr_pkg::DATA_W-1:0] rd_ff, rd_in;
   logic [SW-1:0]                      fpos_ff, fpos_in;
   logic [iarr_pkg::ST_W-1:0]          st_ff, st_in;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [iarr_pkg::DATA_W-1:0]  rsp_rd_ff, rsp_rd_in;
   logic [iarr_pkg::FPOS_W-1:0]         rsp_fpos_ff, rsp_fpos_in;
   logic [iarr_pkg::ST_W-1:0]           rsp_st_ff, rsp_st_in;
   logic [iarr_pkg::CNT_OUT_W-1:0]      rsp_cnt_ff, rsp_cnt_in;
   logic                                rsp_empty_ff, rsp_empty_in;

   // row broadcast
   iarr_pkg::move_type                 move;
   logic [CW-1:0]                      bpos;
   logic signed [iarr_pkg::DATA_W-1:0] cell_value [CAPACITY];
   logic signed [iarr_pkg::DATA_W-1:0] head;

   logic            req_fire;
   logic [MW-1:0]   pos_m, cnt_m, amt_m;
   logic            pos_lt, pos_le, full;

   assign req_fire = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == iarr_pkg::S_IDLE);

   // range and capacity checks in a common width
   assign pos_m  = MW'(pos_ff);
   assign cnt_m  = MW'(count_ff);
   assign amt_m  = MW'(amt_ff);
   assign pos_lt = pos_m < cnt_m;
   assign pos_le = pos_m <= cnt_m;
   assign full   = (count_ff == CW'(CAPACITY));
   assign head   = cell_value[0];
   assign bpos   = (op_ff == iarr_pkg::OP_APPEND) ? count_ff : CW'(pos_ff);

   // row of cells: lower neighbour feeds inserts and right shifts,
   // upper neighbour feeds removes, left shifts and the rotation ring
   genvar g;
   for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [iarr_pkg::DATA_W-1:0] lower_w, upper_w;
      if (g == 0) begin : g_first
         assign lower_w = '0;
      end else begin : g_mid_lo
         assign lower_w = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign upper_w = cell_value[0];
      end else begin : g_mid_hi
         assign upper_w = cell_value[g+1];
      end
      iarr_cell #(.CW(CW), .INDEX(g)) u_cell (
         .clock (clock),
         .move  (move),
         .pos   (bpos),
         .count (count_ff),
         .data  (data_ff),
         .lower (lower_w),
         .upper (upper_w),
         .value (cell_value[g])
      );
   end

   // sequencer: next state, row move and result bookkeeping
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      data_in      = data_ff;
      amt_in       = amt_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      iter_in      = iter_ff;
      rd_in        = rd_ff;
      fpos_in      = fpos_ff;
      st_in        = st_ff;
      move         = iarr_pkg::MV_HOLD;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_rd_in    = rsp_rd_ff;
      rsp_fpos_in  = rsp_fpos_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_empty_in = rsp_empty_ff;

      unique case (state_ff)
         iarr_pkg::S_IDLE: begin
            if (req_fire) begin
               op_in    = req_if.operation;
               pos_in   = req_if.position;
               data_in  = req_if.data_value;
               amt_in   = req_if.shift_amount;
               rd_in    = '0;
               fpos_in  = '0;
               st_in    = iarr_pkg::ST_OK;
               state_in = iarr_pkg::S_EXEC;
            end
         end

         iarr_pkg::S_EXEC: begin
            state_in = iarr_pkg::S_FINISH;
            step_in  = '0;
            unique case (op_ff) inside
               iarr_pkg::OP_READ: begin
                  if (pos_lt) state_in = iarr_pkg::S_ROTATE;
                  else st_in = iarr_pkg::ST_RANGE;
               end
               iarr_pkg::OP_WRITE: begin
                  if (pos_lt) move = iarr_pkg::MV_WRITE;
                  else st_in = iarr_pkg::ST_RANGE;
               end
               iarr_pkg::OP_INSERT: begin
                  if (!pos_le) begin
                     st_in = iarr_pkg::ST_RANGE;
                  end else if (full) begin
                     st_in = iarr_pkg::ST_FULL;
                  end else begin
                     move     = iarr_pkg::MV_INSERT;
                     count_in = count_ff + CW'(1);
                  end
               end
               iarr_pkg::OP_APPEND: begin
                  if (full) begin
                     st_in = iarr_pkg::ST_FULL;
                  end else begin
                     move     = iarr_pkg::MV_INSERT;
                     count_in = count_ff + CW'(1);
                  end
               end
               iarr_pkg::OP_REMOVE: begin
                  if (pos_lt) begin
                     move     = iarr_pkg::MV_REMOVE;
                     count_in = count_ff - CW'(1);
                  end else begin
                     st_in = iarr_pkg::ST_RANGE;
                  end
               end
               iarr_pkg::OP_FIND: begin
                  st_in    = iarr_pkg::ST_MISSING;
                  state_in = iarr_pkg::S_ROTATE;
               end
               iarr_pkg::OP_SHL, iarr_pkg::OP_SHR: begin
                  // one place per pass; count passes zero every live element
                  if (amt_ff != '0 && count_ff != '0) begin
                     iter_in  = (amt_m < cnt_m) ? CW'(amt_ff) : count_ff;
                     state_in = iarr_pkg::S_SHIFT;
                  end
               end
               default: begin
                  state_in = iarr_pkg::S_FINISH;
               end
            endcase
         end

         iarr_pkg::S_ROTATE: begin
            // element step_ff sits in cell 0 during this cycle
            move = iarr_pkg::MV_ROTATE;
            if (op_ff == iarr_pkg::OP_READ && CW'(step_ff) == CW'(pos_ff)) begin
               rd_in = head;
            end
            if (op_ff == iarr_pkg::OP_FIND && st_ff == iarr_pkg::ST_MISSING &&
                CW'(step_ff) < count_ff && head == data_ff) begin
               fpos_in = step_ff;
               st_in   = iarr_pkg::ST_OK;
            end
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(CAPACITY - 1)) state_in = iarr_pkg::S_FINISH;
         end

         iarr_pkg::S_SHIFT: begin
            move    = (op_ff == iarr_pkg::OP_SHL) ? iarr_pkg::MV_SHL : iarr_pkg::MV_SHR;
            iter_in = iter_ff - CW'(1);
            if (iter_ff == CW'(1)) state_in = iarr_pkg::S_FINISH;
         end

         iarr_pkg::S_FINISH: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = rd_ff;
               rsp_fpos_in  = iarr_pkg::FPOS_W'(fpos_ff);
               rsp_st_in    = st_ff;
               rsp_cnt_in   = iarr_pkg::CNT_OUT_W'(count_ff);
               rsp_empty_in = (count_ff == '0);
               state_in     = iarr_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = iarr_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iarr_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      data_ff      <= data_in;
      amt_ff       <= amt_in;
      step_ff      <= step_in;
      iter_ff      <= iter_in;
      rd_ff        <= rd_in;
      fpos_ff      <= fpos_in;
      st_ff        <= st_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_fpos_ff  <= rsp_fpos_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.read_value     = rsp_rd_ff;
   assign rsp_if.found_position = rsp_fpos_ff;
   assign rsp_if.status         = rsp_st_ff;
   assign rsp_if.element_count  = rsp_cnt_ff;
   assign rsp_if.is_empty       = rsp_empty_ff;

   // live count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("live count above capacity");

   // the count moves only in the execute cycle
   a_count_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff != iarr_pkg::S_EXEC) |=> (count_ff == $past(count_ff)))
      else $error("live count changed outside execute");

   // a full rotation ends in finish, leaving the row aligned
   a_rotate_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iarr_pkg::S_ROTATE && step_ff == SW'(CAPACITY - 1))
      |=> (state_ff == iarr_pkg::S_FINISH))
      else $error("rotation did not end after capacity steps");

endmodule

`default_nettype wire
